// File: sv/rsc_pkg.sv
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int DATA_W = 32;
  localparam int REQ_W  = 4;
  localparam int ST_W   = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH  = 4'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 4'd1;
  localparam logic [REQ_W-1:0] REQ_SUB   = 4'd2;
  localparam logic [REQ_W-1:0] REQ_MUL   = 4'd3;
  localparam logic [REQ_W-1:0] REQ_DIV   = 4'd4;
  localparam logic [REQ_W-1:0] REQ_GT    = 4'd5;
  localparam logic [REQ_W-1:0] REQ_LT    = 4'd6;
  localparam logic [REQ_W-1:0] REQ_GE    = 4'd7;
  localparam logic [REQ_W-1:0] REQ_LE    = 4'd8;
  localparam logic [REQ_W-1:0] REQ_EQ    = 4'd9;
  localparam logic [REQ_W-1:0] REQ_SWAP  = 4'd10;
  localparam logic [REQ_W-1:0] REQ_PRINT = 4'd11;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd2;
  localparam logic [ST_W-1:0] ST_DIVZ  = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] push_value;
  } rsc_req_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic                     print_valid;
    logic signed [DATA_W-1:0] print_value;
  } rsc_rsp_t;

  // stack address select
  typedef enum logic [1:0] {
    ADR_TOP,
    ADR_NEXT,
    ADR_CNT
  } rsc_adr_t;

  // stack write data select
  typedef enum logic [1:0] {
    WS_PUSH,
    WS_RES,
    WS_A,
    WS_B
  } rsc_wsel_t;

  typedef struct packed {
    logic      load_req;
    logic      clear_res;
    logic      ram_we;
    rsc_adr_t  adr_sel;
    rsc_wsel_t wsel;
    logic      load_b;
    logic      load_a;
    logic      load_print;
    logic      alu_load;
    logic      div_start;
    logic      load_quot;
    logic      set_divz;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      out_load;
  } rsc_cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_print;
    logic is_swap;
    logic is_div;
    logic is_nop;
    logic err;
    logic b_zero;
    logic div_done;
    logic out_free;
  } rsc_sts_t;

endpackage

// File: sv/rsc_ram.sv
`timescale 1ns / 1ps

module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/rsc_div.sv
`timescale 1ns / 1ps

// restoring divider on magnitudes, one quotient bit a cycle, sign fixed at the end
module rsc_div
  import rsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg;
  logic [DATA_W-1:0] rem_next;
  logic [DATA_W-1:0] quo_next;
  logic [DATA_W:0]   trial;

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  always_comb begin
    trial = {rem, quo[DATA_W-1]} - {1'b0, dvs};
    if (!trial[DATA_W]) begin
      rem_next = trial[DATA_W-1:0];
      quo_next = {quo[DATA_W-2:0], 1'b1};
    end else begin
      rem_next = {rem[DATA_W-2:0], quo[DATA_W-1]};
      quo_next = {quo[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= mag(dividend);
      dvs <= mag(divisor);
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = neg ? (~quo + DATA_W'(1)) : quo;

endmodule

// File: sv/rsc_datapath.sv
`timescale 1ns / 1ps

module rsc_datapath
  import rsc_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  rsc_req_t req,
  input  logic     rsp_ready,
  output logic     rsp_valid,
  output rsc_rsp_t rsp,
  input  rsc_cmd_t cmd,
  output rsc_sts_t sts
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  rsc_req_t          req_reg;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] b_reg;
  logic [DATA_W-1:0] a_reg;
  logic [DATA_W-1:0] r_reg;
  logic [ST_W-1:0]   res_status;
  logic              res_pvalid;
  logic [DATA_W-1:0] res_pval;

  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [ADDR_W-1:0] ram_addr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] mul_lo;
  logic signed [DATA_W-1:0] a_op;
  logic signed [DATA_W-1:0] b_op;
  logic              div_done;
  logic [DATA_W-1:0] div_quot;
  logic              under;
  logic              over;
  logic              binop;

  // decode of the held request
  assign binop = (req_reg.req_type >= REQ_ADD) && (req_reg.req_type <= REQ_SWAP);
  assign under = ((req_reg.req_type == REQ_PRINT) && (count == '0))
              || (binop && (count < CNT_W'(2)));
  assign over  = (req_reg.req_type == REQ_PUSH) && (count == CNT_W'(STACK_DEPTH));

  assign sts.is_push  = req_reg.req_type == REQ_PUSH;
  assign sts.is_print = req_reg.req_type == REQ_PRINT;
  assign sts.is_swap  = req_reg.req_type == REQ_SWAP;
  assign sts.is_div   = req_reg.req_type == REQ_DIV;
  assign sts.is_nop   = req_reg.req_type > REQ_PRINT;
  assign sts.err      = under || over;
  assign sts.b_zero   = b_reg == '0;
  assign sts.div_done = div_done;
  assign sts.out_free = !rsp_valid || rsp_ready;

  // stack memory port
  assign cnt_m1 = count - CNT_W'(1);
  assign cnt_m2 = count - CNT_W'(2);

  always_comb begin
    unique case (cmd.adr_sel)
      ADR_TOP:  ram_addr = cnt_m1[ADDR_W-1:0];
      ADR_NEXT: ram_addr = cnt_m2[ADDR_W-1:0];
      ADR_CNT:  ram_addr = count[ADDR_W-1:0];
      default:  ram_addr = count[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.wsel)
      WS_PUSH: ram_wdata = req_reg.push_value;
      WS_RES:  ram_wdata = r_reg;
      WS_A:    ram_wdata = a_reg;
      WS_B:    ram_wdata = b_reg;
      default: ram_wdata = r_reg;
    endcase
  end

  rsc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ALU: A arrives straight from the memory read, B from b_reg, loaded in the cycle before
  assign a_op   = ram_rdata;
  assign b_op   = b_reg;
  assign mul_lo = a_op * b_op;

  always_comb begin
    unique case (req_reg.req_type)
      REQ_ADD: alu_res = a_op + b_op;
      REQ_SUB: alu_res = a_op - b_op;
      REQ_MUL: alu_res = mul_lo;
      REQ_GT:  alu_res = DATA_W'(a_op > b_op);
      REQ_LT:  alu_res = DATA_W'(a_op < b_op);
      REQ_GE:  alu_res = DATA_W'(a_op >= b_op);
      REQ_LE:  alu_res = DATA_W'(a_op <= b_op);
      REQ_EQ:  alu_res = DATA_W'(a_op == b_op);
      default: alu_res = '0;
    endcase
  end

  rsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (ram_rdata),
    .divisor  (b_reg),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_reg <= req;
    end
    if (cmd.load_b) begin
      b_reg <= ram_rdata;
    end
    if (cmd.load_a) begin
      a_reg <= ram_rdata;
    end
    if (cmd.alu_load) begin
      r_reg <= alu_res;
    end else if (cmd.load_quot) begin
      r_reg <= div_quot;
    end
    if (cmd.clear_res) begin
      res_status <= under ? ST_UNDER : (over ? ST_OVER : ST_OK);
      res_pvalid <= 1'b0;
      res_pval   <= '0;
    end else if (cmd.set_divz) begin
      res_status <= ST_DIVZ;
    end else if (cmd.load_print) begin
      res_pvalid <= 1'b1;
      res_pval   <= ram_rdata;
    end
    if (cmd.out_load) begin
      rsp.status      <= res_status;
      rsp.print_valid <= res_pvalid;
      rsp.print_value <= res_pval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= cnt_m1;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/rsc_ctrl.sv
`timescale 1ns / 1ps

module rsc_ctrl
  import rsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  rsc_sts_t sts,
  output rsc_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_FETCH  = 8'b0000_0100,
    S_OPER   = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_WRITE  = 8'b0010_0000,
    S_SWAP   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.load_req = req_valid;
        if (req_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.clear_res = 1'b1;
        priority if (sts.err || sts.is_nop) begin
          state_next = S_FINISH;
        end else if (sts.is_push) begin
          cmd.ram_we  = 1'b1;
          cmd.adr_sel = ADR_CNT;
          cmd.wsel    = WS_PUSH;
          cmd.cnt_inc = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.adr_sel = ADR_TOP;
          state_next  = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.load_b  = 1'b1;
        cmd.adr_sel = ADR_NEXT;
        if (sts.is_print) begin
          cmd.load_print = 1'b1;
          cmd.cnt_dec    = 1'b1;
          state_next     = S_FINISH;
        end else begin
          state_next = S_OPER;
        end
      end
      S_OPER: begin
        cmd.load_a = 1'b1;
        priority if (sts.is_swap) begin
          cmd.ram_we  = 1'b1;
          cmd.adr_sel = ADR_NEXT;
          cmd.wsel    = WS_B;
          state_next  = S_SWAP;
        end else if (sts.is_div && sts.b_zero) begin
          cmd.set_divz = 1'b1;
          state_next   = S_FINISH;
        end else if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.alu_load = 1'b1;
          state_next   = S_WRITE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.load_quot = 1'b1;
          state_next    = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.ram_we  = 1'b1;
        cmd.adr_sel = ADR_NEXT;
        cmd.wsel    = WS_RES;
        cmd.cnt_dec = 1'b1;
        state_next  = S_FINISH;
      end
      S_SWAP: begin
        cmd.ram_we  = 1'b1;
        cmd.adr_sel = ADR_TOP;
        cmd.wsel    = WS_A;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/rpn_stack_calculator.sv
`timescale 1ns / 1ps

// Channel  Handshake            Word       Carries
// request  req_valid/req_ready  req        req_type, push_value
// result   rsp_valid/rsp_ready  rsp        status, print_valid, print_value
//
// One word in, one word out. Push, no-op, underflow and overflow go from decode
// to finish; print adds a fetch; divide by zero adds fetch and operate; other
// operations also write back or swap, divide after the bit-serial divider is done.
// The stack is a single-port memory, so the top two entries are read in turn.
// Reset clears the stack count, the controller, the divider and output valid.
// A waiting result lets the next request in; that one stalls at finish until it is taken.

module rpn_stack_calculator
  import rsc_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  rsc_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output rsc_rsp_t rsp
);

  rsc_cmd_t cmd;
  rsc_sts_t sts;

  // sequencer: walks each request through decode, fetch, operate and write back or swap, as its type needs
  rsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stack memory, count, ALU, divider and result register
  rsc_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

  // a print word only ever leaves with an ok status
  a_print_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.print_valid |-> rsp.status == ST_OK)
    else $error("print word with error status");

  // non-print words carry a zero value
  a_print_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.print_valid |-> rsp.print_value == '0)
    else $error("non-print word with nonzero value");

  // the stack is only written while a request is in flight
  a_we_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.ram_we |-> !req_ready)
    else $error("stack write while idle");

  // one request at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

endmodule
